>>> hw/rtl/dwgs_pkg.sv
// Shared constants, codes and types for the damped wave grid step block.
`timescale 1ns / 1ps

package dwgs_pkg;

   // mesh geometry
   localparam int GRID_SIDE = 64;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int XY_W      = $clog2(GRID_SIDE);
   localparam int RY_W      = $clog2(GRID_SIDE + 1);
   localparam int R_W       = $clog2(CELLS + GRID_SIDE);
   localparam int TAPS      = 2 * GRID_SIDE;

   // field widths
   localparam int MODE_W     = 2;
   localparam int IDX_W      = 12;
   localparam int VAL_W      = 24;
   localparam int AMP_W      = 17;
   localparam int COEF_W     = 16;
   localparam int RAD_W      = 12;
   localparam int STEP_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // arithmetic
   localparam int COEF_SHIFT = 16;
   localparam int LAP_W      = VAL_W + 3;
   localparam int ACC_W      = 48;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WRITE_DRIVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_FIELD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEP        = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ        = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COURANT_SQ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ  = 2'd2;

   localparam logic [COEF_W-1:0] DAMPING_RESET    = 16'd328;
   localparam logic [COEF_W-1:0] COURANT_SQ_RESET = 16'd1285;
   localparam logic [RAD_W-1:0]  RADIUS_SQ_RESET  = 12'd900;

   // mesh position handed to the stencil with the read data
   typedef struct packed {
      logic              valid;
      logic [XY_W-1:0]   x;
      logic [XY_W-1:0]   y;
      logic [ADDR_W-1:0] addr;
   } cell_ctl_type;

   // write-back of one new field value
   typedef struct packed {
      logic                    en;
      logic [ADDR_W-1:0]       addr;
      logic signed [VAL_W-1:0] data;
   } cell_wr_type;

endpackage

>>> hw/rtl/dwgs_stencil.sv
// Stencil pipeline: row window, Laplacian, basin test, products, rounding.
`timescale 1ns / 1ps

module dwgs_stencil (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    shift_en,
   input  dwgs_pkg::cell_ctl_type                  ctl,
   input  logic signed [dwgs_pkg::VAL_W-1:0]       cur_q,
   input  logic signed [dwgs_pkg::VAL_W-1:0]       prev_q,
   input  logic signed [dwgs_pkg::VAL_W-1:0]       drive_q,
   input  logic        [dwgs_pkg::COEF_W-1:0]      damping,
   input  logic        [dwgs_pkg::COEF_W-1:0]      courant_sq,
   input  logic        [dwgs_pkg::RAD_W-1:0]       radius_sq,
   input  logic signed [dwgs_pkg::AMP_W-1:0]       amplitude,
   output dwgs_pkg::cell_wr_type                   wr,
   output logic                                    busy
);
   import dwgs_pkg::*;

   localparam int DXY_W = XY_W + 1;
   localparam int DSQ_W = 2 * DXY_W;
   localparam int C2_W  = COEF_SHIFT + 3;
   localparam int C1_W  = COEF_SHIFT + 2;
   localparam int CF_W  = COEF_W + 1;

   // window over the last two rows of the current field
   logic signed [VAL_W-1:0] sr_ff [TAPS];

   logic signed [VAL_W-1:0] north, south, east, west, centre;
   logic signed [LAP_W-1:0] lap_in;
   logic signed [DXY_W-1:0] dx, dy;
   logic [DSQ_W-1:0]        dsq_x, dsq_y;
   logic [DSQ_W:0]          dist_sq;
   logic                    interior, inside_in;

   logic signed [C2_W-1:0]  c2;
   logic signed [C1_W-1:0]  c1;
   logic signed [CF_W-1:0]  cf;

   logic                    s2_valid_ff, s2_inside_ff;
   logic [ADDR_W-1:0]       s2_addr_ff;
   logic signed [VAL_W-1:0] s2_u_ff, s2_prev_ff, s2_drive_ff;
   logic signed [LAP_W-1:0] s2_lap_ff;

   logic                    s3_valid_ff, s3_inside_ff;
   logic [ADDR_W-1:0]       s3_addr_ff;
   logic signed [ACC_W-1:0] s3_pu_ff, s3_pp_ff, s3_pl_ff, s3_pd_ff;

   logic                    s4_valid_ff, s4_inside_ff;
   logic [ADDR_W-1:0]       s4_addr_ff;
   logic signed [ACC_W-1:0] s4_acc_ff;

   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W-VAL_W:0]    hi_bits;
   logic signed [VAL_W-1:0] sat;
   cell_wr_type             wr_ff, wr_in;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sr_ff[0] <= cur_q;
         for (int k = 1; k < TAPS; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign south  = cur_q;
   assign east   = sr_ff[GRID_SIDE-2];
   assign centre = sr_ff[GRID_SIDE-1];
   assign west   = sr_ff[GRID_SIDE];
   assign north  = sr_ff[TAPS-1];

   assign lap_in = LAP_W'(north) + LAP_W'(south) + LAP_W'(east) + LAP_W'(west)
                 - (LAP_W'(centre) <<< 2);

   // basin test, centre of the mesh at (side/2, side/2)
   assign dx      = $signed({1'b0, ctl.x}) - $signed(DXY_W'(GRID_SIDE / 2));
   assign dy      = $signed({1'b0, ctl.y}) - $signed(DXY_W'(GRID_SIDE / 2));
   assign dsq_x   = DSQ_W'(dx * dx);
   assign dsq_y   = DSQ_W'(dy * dy);
   assign dist_sq = (DSQ_W+1)'(dsq_x) + (DSQ_W+1)'(dsq_y);

   assign interior  = (ctl.x != '0) && (ctl.x != XY_W'(GRID_SIDE - 1))
                   && (ctl.y != '0) && (ctl.y != XY_W'(GRID_SIDE - 1));
   assign inside_in = interior && (32'(dist_sq) < 32'(radius_sq));

   // (2-d), (1-d) and cf, all with COEF_SHIFT fraction bits
   assign c2 = C2_W'(2 ** (COEF_SHIFT + 1)) - C2_W'(damping);
   assign c1 = C1_W'(2 ** COEF_SHIFT) - C1_W'(damping);
   assign cf = $signed({1'b0, courant_sq});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= shift_en && ctl.valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_inside_ff <= inside_in;
      s2_addr_ff   <= ctl.addr;
      s2_u_ff      <= centre;
      s2_prev_ff   <= prev_q;
      s2_drive_ff  <= drive_q;
      s2_lap_ff    <= lap_in;

      s3_inside_ff <= s2_inside_ff;
      s3_addr_ff   <= s2_addr_ff;
      s3_pu_ff     <= ACC_W'(s2_u_ff * c2);
      s3_pp_ff     <= ACC_W'(s2_prev_ff * c1);
      s3_pl_ff     <= ACC_W'(s2_lap_ff * cf);
      s3_pd_ff     <= ACC_W'(s2_drive_ff * amplitude);

      s4_inside_ff <= s3_inside_ff;
      s4_addr_ff   <= s3_addr_ff;
      s4_acc_ff    <= s3_pu_ff - s3_pp_ff + s3_pl_ff + s3_pd_ff
                    + ACC_W'(2 ** (COEF_SHIFT - 1));
   end

   // round half up is done by the bias above; floor shift then saturate
   assign shifted = s4_acc_ff >>> COEF_SHIFT;
   assign hi_bits = shifted[ACC_W-1:VAL_W-1];

   always_comb begin
      if ((&hi_bits) || !(|hi_bits)) begin
         sat = shifted[VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VAL_W-1){1'b1}}};
      end
      wr_in.en   = s4_valid_ff;
      wr_in.addr = s4_addr_ff;
      wr_in.data = s4_inside_ff ? sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff.en <= 1'b0;
      end else begin
         wr_ff.en <= wr_in.en;
      end
      wr_ff.addr <= wr_in.addr;
      wr_ff.data <= wr_in.data;
   end

   assign wr   = wr_ff;
   assign busy = s2_valid_ff || s3_valid_ff || s4_valid_ff || wr_ff.en;

endmodule

>>> hw/rtl/damped_wave_grid_step.sv
// Top level of the damped wave grid step block: field banks, drive memory,
// sequencer and register file.
//
// A request is taken when start is high and busy is low. Drive and field
// writes are answered from the idle state; a field read passes through a
// read state first, since the bank read port is registered. A time step
// sweeps the current bank once with a single read per cell, starting one
// row ahead so that the row window holds both vertical neighbours, and
// keeps busy high through the sweep and the drain; the sweep length is set
// by the one read port of the current bank. Each request gives exactly
// one response, shown for one cycle with rsp_valid high; the receiver cannot
// stall it, and responses come in request order. After reset the block runs
// a clearing pass over every cell of both field banks and the drive memory,
// with busy high; register writes are taken during it. The two field
// banks swap roles at the end of each step, so the new field is written over
// the previous one and no copy is needed. Registers should be written only
// while busy is low and no response is outstanding.
`timescale 1ns / 1ps

module damped_wave_grid_step (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [dwgs_pkg::MODE_W-1:0]     req_mode,
   input  logic        [dwgs_pkg::IDX_W-1:0]      req_cell_index,
   input  logic signed [dwgs_pkg::VAL_W-1:0]      req_cell_value,
   input  logic signed [dwgs_pkg::AMP_W-1:0]      req_amplitude,
   // response channel
   output logic                                   rsp_valid,
   output logic signed [dwgs_pkg::VAL_W-1:0]      rsp_read_value,
   output logic        [dwgs_pkg::STEP_W-1:0]     rsp_steps_done,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [dwgs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [dwgs_pkg::CSR_DATA_W-1:0] csr_data
);
   import dwgs_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [COEF_W-1:0] damping_ff, courant_sq_ff;
   logic [RAD_W-1:0]  radius_sq_ff;

   // sequencer state
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic                    bank_ff, bank_in;     // high: bank B holds the current field
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [R_W-1:0]          r_ff, r_in;           // sweep read address
   logic [XY_W-1:0]         rx_ff, rx_in;
   logic [RY_W-1:0]         ry_ff, ry_in;
   logic signed [AMP_W-1:0] amp_ff, amp_in;
   logic                    shift_ff;
   cell_ctl_type            ctl_ff, ctl_in;

   // response registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STEP_W-1:0]       rsp_steps_ff, rsp_steps_in;

   // memories
   logic signed [VAL_W-1:0] bank_a [CELLS];
   logic signed [VAL_W-1:0] bank_b [CELLS];
   logic signed [VAL_W-1:0] drive_mem [CELLS];

   logic                    a_we, b_we, d_we;
   logic [ADDR_W-1:0]       a_waddr, b_waddr, d_waddr;
   logic signed [VAL_W-1:0] a_wdata, b_wdata, d_wdata;
   logic [ADDR_W-1:0]       a_raddr, b_raddr;
   logic signed [VAL_W-1:0] a_q, b_q, d_q;

   logic                    accept, idx_ok, clearing, sweeping;
   logic                    fld_we, drv_we;
   logic [ADDR_W-1:0]       req_addr, cur_raddr, sweep_addr;
   logic signed [VAL_W-1:0] cur_q, prev_q;

   cell_wr_type             st_wr;
   logic                    st_busy;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign clearing = (state_ff == ST_CLEAR);
   assign sweeping = (state_ff == ST_SWEEP);

   // indexes at or beyond the mesh size are ignored by writes, read as zero
   assign idx_ok   = 32'(req_cell_index) < 32'(CELLS);
   assign req_addr = ADDR_W'(req_cell_index);
   assign fld_we   = accept && (req_mode == MODE_WRITE_FIELD) && idx_ok;
   assign drv_we   = accept && (req_mode == MODE_WRITE_DRIVE) && idx_ok;

   // the cell being updated trails the current-field read by one row
   assign cur_raddr  = sweeping ? ADDR_W'(r_ff) : req_addr;
   assign sweep_addr = ADDR_W'(r_ff - R_W'(GRID_SIDE));

   assign a_raddr = bank_ff ? sweep_addr : cur_raddr;
   assign b_raddr = bank_ff ? cur_raddr : sweep_addr;
   assign cur_q   = bank_ff ? b_q : a_q;
   assign prev_q  = bank_ff ? a_q : b_q;

   // write ports: clearing pass, request writes to the current bank,
   // stencil write-back into the previous bank (read there before written)
   always_comb begin
      a_we    = 1'b0;
      a_waddr = st_wr.addr;
      a_wdata = st_wr.data;
      if (clearing) begin
         a_we    = 1'b1;
         a_waddr = clr_ff;
         a_wdata = '0;
      end else if (!bank_ff) begin
         a_we    = fld_we;
         a_waddr = req_addr;
         a_wdata = req_cell_value;
      end else begin
         a_we    = st_wr.en;
      end
   end

   always_comb begin
      b_we    = 1'b0;
      b_waddr = st_wr.addr;
      b_wdata = st_wr.data;
      if (clearing) begin
         b_we    = 1'b1;
         b_waddr = clr_ff;
         b_wdata = '0;
      end else if (bank_ff) begin
         b_we    = fld_we;
         b_waddr = req_addr;
         b_wdata = req_cell_value;
      end else begin
         b_we    = st_wr.en;
      end
   end

   always_comb begin
      if (clearing) begin
         d_we    = 1'b1;
         d_waddr = clr_ff;
         d_wdata = '0;
      end else begin
         d_we    = drv_we;
         d_waddr = req_addr;
         d_wdata = req_cell_value;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         bank_a[a_waddr] <= a_wdata;
      end
      a_q <= bank_a[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bank_b[b_waddr] <= b_wdata;
      end
      b_q <= bank_b[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         drive_mem[d_waddr] <= d_wdata;
      end
      d_q <= drive_mem[sweep_addr];
   end

   // position of the cell whose operands arrive with this read
   always_comb begin
      ctl_in.valid = (ry_ff != '0);
      ctl_in.x     = rx_ff;
      ctl_in.y     = XY_W'(ry_ff - RY_W'(1));
      ctl_in.addr  = sweep_addr;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      bank_in      = bank_ff;
      step_in      = step_ff;
      r_in         = r_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      amp_in       = amp_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_steps_in = rsp_steps_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_STEP: begin
                     amp_in   = req_amplitude;
                     r_in     = '0;
                     rx_in    = '0;
                     ry_in    = '0;
                     state_in = ST_SWEEP;
                  end
                  MODE_READ: begin
                     if (idx_ok) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_steps_in = step_ff;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_steps_in = step_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = cur_q;
            rsp_steps_in = step_ff;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            r_in = r_ff + R_W'(1);
            if (rx_ff == XY_W'(GRID_SIDE - 1)) begin
               rx_in = '0;
               ry_in = ry_ff + RY_W'(1);
               if (ry_ff == RY_W'(GRID_SIDE)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               rx_in = rx_ff + XY_W'(1);
            end
         end
         ST_DRAIN: begin
            // last write-back done: swap banks and report
            if (!shift_ff && !st_busy) begin
               bank_in      = ~bank_ff;
               step_in      = step_ff + STEP_W'(1);
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_steps_in = step_ff + STEP_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bank_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bank_ff      <= bank_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= sweeping;
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.x     <= ctl_in.x;
      ctl_ff.y     <= ctl_in.y;
      ctl_ff.addr  <= ctl_in.addr;
      r_ff         <= r_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      amp_ff       <= amp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   // register file, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff    <= DAMPING_RESET;
         courant_sq_ff <= COURANT_SQ_RESET;
         radius_sq_ff  <= RADIUS_SQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DAMPING:    damping_ff    <= csr_data;
            CSR_COURANT_SQ: courant_sq_ff <= csr_data;
            CSR_RADIUS_SQ:  radius_sq_ff  <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   dwgs_stencil u_stencil (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (shift_ff),
      .ctl        (ctl_ff),
      .cur_q      (cur_q),
      .prev_q     (prev_q),
      .drive_q    (d_q),
      .damping    (damping_ff),
      .courant_sq (courant_sq_ff),
      .radius_sq  (radius_sq_ff),
      .amplitude  (amp_ff),
      .wr         (st_wr),
      .busy       (st_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_steps_done = rsp_steps_ff;

endmodule

>>> tb/wave_grid_checker.sv
// Request/response checker for the damped wave grid step block.
`timescale 1ns / 1ps

module wave_grid_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic        [dwgs_pkg::MODE_W-1:0]     req_mode,
   input  logic        [dwgs_pkg::IDX_W-1:0]      req_cell_index,
   input  logic signed [dwgs_pkg::VAL_W-1:0]      req_cell_value,
   input  logic signed [dwgs_pkg::AMP_W-1:0]      req_amplitude,
   input  logic                                   rsp_valid,
   input  logic signed [dwgs_pkg::VAL_W-1:0]      rsp_read_value,
   input  logic        [dwgs_pkg::STEP_W-1:0]     rsp_steps_done,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic        [dwgs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [dwgs_pkg::CSR_DATA_W-1:0] csr_data,
   output int unsigned                            mismatches,
   output int unsigned                            pending
);
   import dwgs_pkg::*;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [STEP_W-1:0]       steps_done;
   } response_type;

   logic signed [VAL_W-1:0] field_now  [CELLS];
   logic signed [VAL_W-1:0] field_old  [CELLS];
   logic signed [VAL_W-1:0] field_next [CELLS];
   logic signed [VAL_W-1:0] drive_map  [CELLS];
   logic [STEP_W-1:0]       step_count;
   logic [COEF_W-1:0]       damping;
   logic [COEF_W-1:0]       courant_sq;
   logic [RAD_W-1:0]        radius_sq;
   response_type            awaited[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // one leapfrog step over the whole mesh; off-basin and border cells go to zero
   function automatic void advance_field(input logic signed [AMP_W-1:0] amp);
      longint two_m_d, one_m_d, u, lap, acc, r;
      int     i, dx, dy;
      two_m_d = (longint'(1) <<< (COEF_SHIFT + 1)) - longint'(damping);
      one_m_d = (longint'(1) <<< COEF_SHIFT) - longint'(damping);
      for (int c = 0; c < CELLS; c++) field_next[c] = '0;
      for (int y = 1; y < GRID_SIDE - 1; y++) begin
         for (int x = 1; x < GRID_SIDE - 1; x++) begin
            i  = y * GRID_SIDE + x;
            dx = x - GRID_SIDE / 2;
            dy = y - GRID_SIDE / 2;
            if (dx * dx + dy * dy < int'(radius_sq)) begin
               u   = longint'(field_now[i]);
               lap = longint'(field_now[i + 1]) + longint'(field_now[i - 1])
                   + longint'(field_now[i + GRID_SIDE]) + longint'(field_now[i - GRID_SIDE])
                   - 4 * u;
               acc = two_m_d * u - one_m_d * longint'(field_old[i])
                   + longint'(courant_sq) * lap
                   + longint'(amp) * longint'(drive_map[i]);
               // round half up, then clamp to Q8.16
               r = (acc + (longint'(1) <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
               if (r > 64'sd8388607) r = 64'sd8388607;
               if (r < -64'sd8388608) r = -64'sd8388608;
               field_next[i] = r[VAL_W-1:0];
            end
         end
      end
      field_old  = field_now;
      field_now  = field_next;
      step_count = step_count + STEP_W'(1);
   endfunction

   function automatic response_type predict_request(input logic [MODE_W-1:0] mode,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic signed [VAL_W-1:0] value,
                                                    input logic signed [AMP_W-1:0] amp);
      response_type rsp;
      logic         in_range;
      rsp.read_value = '0;
      in_range       = int'(idx) < CELLS;
      case (mode)
         MODE_WRITE_DRIVE: if (in_range) drive_map[idx] = value;
         MODE_WRITE_FIELD: if (in_range) field_now[idx] = value;
         MODE_STEP:        advance_field(amp);
         default:          if (in_range) rsp.read_value = field_now[idx];
      endcase
      rsp.steps_done = step_count;
      return rsp;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         for (int c = 0; c < CELLS; c++) begin
            field_now[c] = '0;
            field_old[c] = '0;
            drive_map[c] = '0;
         end
         step_count = '0;
         damping    = DAMPING_RESET;
         courant_sq = COURANT_SQ_RESET;
         radius_sq  = RADIUS_SQ_RESET;
         awaited.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               report_mismatch("unrequested response, steps_done", rsp_steps_done, -1);
            end else begin
               want = awaited.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_steps_done !== want.steps_done)
                  report_mismatch("steps_done", rsp_steps_done, want.steps_done);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DAMPING:    damping    = csr_data;
               CSR_COURANT_SQ: courant_sq = csr_data;
               CSR_RADIUS_SQ:  radius_sq  = csr_data[RAD_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            awaited.push_back(predict_request(req_mode, req_cell_index, req_cell_value,
                                              req_amplitude));
      end
      pending = awaited.size();
   end

endmodule

>>> tb/testbench.sv
// Top of the damped wave grid step testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import dwgs_pkg::*;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         start          = 1'b0;
   logic                         busy;
   logic        [MODE_W-1:0]     req_mode       = MODE_READ;
   logic        [IDX_W-1:0]      req_cell_index = '0;
   logic signed [VAL_W-1:0]      req_cell_value = '0;
   logic signed [AMP_W-1:0]      req_amplitude  = '0;
   logic                         rsp_valid;
   logic signed [VAL_W-1:0]      rsp_read_value;
   logic        [STEP_W-1:0]     rsp_steps_done;
   logic                         csr_valid      = 1'b0;
   logic                         csr_ready;
   logic        [CSR_IDX_W-1:0]  csr_index      = CSR_DAMPING;
   logic        [CSR_DATA_W-1:0] csr_data       = '0;
   int unsigned                  mismatches;
   int unsigned                  pending;

   // chance, in percent, that the sender holds off for a cycle
   int unsigned idle_pct   = 9;
   // time steps left for the random part
   int unsigned steps_left = 22;

   localparam int RANDOM_ITEMS = 120;
   localparam int PHASES       = 5;
   localparam int CENTRE       = GRID_SIDE / 2;

   always #10 clock = ~clock;

   damped_wave_grid_step dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_cell_index, .req_cell_value, .req_amplitude,
      .rsp_valid, .rsp_read_value, .rsp_steps_done,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   wave_grid_checker grid_check (
      .clock, .reset, .start, .busy,
      .req_mode, .req_cell_index, .req_cell_value, .req_amplitude,
      .rsp_valid, .rsp_read_value, .rsp_steps_done,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .pending
   );

   function automatic logic [IDX_W-1:0] cell_at(input int x, input int y);
      return IDX_W'(y * GRID_SIDE + x);
   endfunction

   // Presents one request and returns at the edge that takes it. start is
   // left high, so a following request goes out back to back unless the
   // random hold-off drops it.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                               input logic signed [VAL_W-1:0] value,
                               input logic signed [AMP_W-1:0] amp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_cell_index <= idx;
      req_cell_value <= value;
      req_amplitude  <= amp;
      do @(posedge clock); while (busy);
   endtask

   // Sender pauses until every response is in and the block is idle.
   // Sampled on the falling edge so the checker's count is settled.
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly works around the basin centre so that writes, steps and reads
   // interact; a share of pure noise covers the whole address and value space.
   task automatic random_request();
      int unsigned              roll;
      logic [MODE_W-1:0]        mode;
      logic [IDX_W-1:0]         idx;
      logic signed [VAL_W-1:0]  value;
      logic signed [AMP_W-1:0]  amp;
      roll = $urandom_range(99);
      idx  = cell_at(CENTRE - 8 + $urandom_range(16), CENTRE - 8 + $urandom_range(16));
      if ($urandom_range(1))
         value = VAL_W'($urandom);
      else
         value = VAL_W'(int'($urandom_range(1 << 19)) - (1 << 18));
      case ($urandom_range(3))
         0:       amp = {1'b0, {(AMP_W-1){1'b1}}};
         1:       amp = {1'b1, {(AMP_W-1){1'b0}}};
         default: amp = AMP_W'($urandom);
      endcase
      if (roll < 8) begin
         mode = MODE_W'($urandom_range(3));
         idx  = IDX_W'($urandom);
         amp  = AMP_W'($urandom);
      end else if (roll < 30) begin
         mode = MODE_WRITE_FIELD;
      end else if (roll < 48) begin
         mode = MODE_WRITE_DRIVE;
      end else if (roll < 62) begin
         mode = MODE_STEP;
      end else begin
         mode = MODE_READ;
      end
      if (mode == MODE_STEP) begin
         if (steps_left == 0) mode = MODE_READ;
         else steps_left--;
      end
      send_request(mode, idx, value, amp);
   endtask

   initial begin
      logic [COEF_W-1:0] damp_set    [PHASES];
      logic [COEF_W-1:0] courant_set [PHASES];
      logic [RAD_W-1:0]  radius_set  [PHASES];
      int                item;
      int                guard;

      // high extremes (radius past its nominal range covers the whole
      // interior), all zero (empty basin), two random settings and a
      // no-damping / full-Courant mix
      damp_set    = '{16'hFFFF, 16'd0, COEF_W'($urandom), 16'd0, COEF_W'($urandom)};
      courant_set = '{16'hFFFF, 16'd0, COEF_W'($urandom), 16'hFFFF, COEF_W'($urandom)};
      radius_set  = '{12'hFFF, 12'd0, RAD_W'($urandom_range(2048)), 12'd2048,
                      RAD_W'($urandom_range(1100, 100))};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset register values; first request waits out
      // the clearing pass
      send_request(MODE_READ, cell_at(0, 0), 24'sd5, 17'sd3);
      send_request(MODE_WRITE_FIELD, cell_at(CENTRE, CENTRE), 24'sh7FFFFF, '0);
      send_request(MODE_WRITE_FIELD, cell_at(CENTRE + 1, CENTRE), 24'sh800000, '0);
      send_request(MODE_WRITE_DRIVE, cell_at(CENTRE, CENTRE), 24'sh7FFFFF, '0);
      send_request(MODE_WRITE_DRIVE, cell_at(CENTRE - 1, CENTRE), 24'sh800000, '0);
      // corner cell is on the border: written, read back, then cleared by a step
      send_request(MODE_WRITE_FIELD, 12'hFFF, 24'sd12345, '0);
      send_request(MODE_READ, 12'hFFF, '0, '0);
      send_request(MODE_STEP, '0, '0, 17'sh0FFFF);
      send_request(MODE_READ, cell_at(CENTRE, CENTRE), '0, '0);
      send_request(MODE_READ, cell_at(CENTRE + 1, CENTRE), '0, '0);
      send_request(MODE_READ, cell_at(CENTRE - 1, CENTRE), '0, '0);
      send_request(MODE_READ, cell_at(CENTRE, CENTRE - 1), '0, '0);
      send_request(MODE_READ, 12'hFFF, '0, '0);
      send_request(MODE_STEP, 12'hFFF, 24'shFFFFFF, 17'sh10000);
      send_request(MODE_READ, cell_at(CENTRE, CENTRE), '0, '0);
      send_request(MODE_READ, cell_at(CENTRE + 1, CENTRE + 1), '0, '0);
      send_request(MODE_WRITE_FIELD, cell_at(0, CENTRE), 24'sd777, '0);
      send_request(MODE_STEP, '0, '0, '0);
      send_request(MODE_READ, cell_at(0, CENTRE), '0, '0);
      send_request(MODE_READ, cell_at(CENTRE, CENTRE), '0, '0);
      wait_idle();

      // random part: a register setting per phase, written with the block idle
      item = 0;
      for (int p = 0; p < PHASES; p++) begin
         write_register(CSR_DAMPING, damp_set[p]);
         write_register(CSR_COURANT_SQ, courant_set[p]);
         write_register(CSR_RADIUS_SQ, CSR_DATA_W'(radius_set[p]));
         repeat (RANDOM_ITEMS / PHASES) begin
            // pacing: light hold-off, heavy hold-off, then flat out
            idle_pct = (item < RANDOM_ITEMS / 3) ? 9 : (item < 2 * RANDOM_ITEMS / 3) ? 46 : 0;
            random_request();
            item++;
         end
         wait_idle();
      end

      // drain with a bound, then wait for stray responses before the verdict
      start <= 1'b0;
      guard = 0;
      while (pending != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // timeout at several times the slowest legal run
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
